@@ rtl/core/prs_lz_pkg.sv @@
package prs_lz_pkg;

	// history window
	localparam int HIST_DEPTH = 8192;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	// field and state widths
	localparam int CNT_W   = 24;
	localparam int DIST_W  = 14;
	localparam int COPY_W  = 9;
	localparam int SLEN_W  = 3;
	localparam int BL_W    = 4;
	localparam int BYTE_W  = 8;

	// parser unroll depth: up to four control bits, one byte, four more bits, one stop
	localparam int PARSE_STEPS = 10;

	// match decode constants
	localparam logic [DIST_W-1:0] LONG_BASE   = DIST_W'(14'h2000);
	localparam logic [DIST_W-1:0] SHORT_BASE  = DIST_W'(14'h100);
	localparam logic [COPY_W-1:0] LONG_ADD    = COPY_W'(2);
	localparam logic [COPY_W-1:0] EXT_ADD     = COPY_W'(10);
	localparam logic [BL_W-1:0]   CTRL_BITS_N = BL_W'(8);

	typedef enum logic [2:0] {
		PH_TOP   = 3'd0,
		PH_BIT   = 3'd1,
		PH_BIT2  = 3'd2,
		PH_SHORT = 3'd3,
		PH_LIT   = 3'd4,
		PH_LO    = 3'd5,
		PH_HI    = 3'd6,
		PH_ONE   = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ST_RUN    = 3'd0,
		ST_END    = 3'd1,
		ST_SRC    = 3'd2,
		ST_OVF    = 3'd3,
		ST_MISUSE = 3'd4
	} status_t;

	// per-transaction result and history access from the decoder
	typedef struct packed {
		logic                ov;
		logic                from_ram;
		logic                pend;
		status_t             status;
		logic [BYTE_W-1:0]   lit;
		logic [HIST_AW-1:0]  raddr;
		logic [HIST_AW-1:0]  waddr;
	} step_t;

endpackage

@@ rtl/core/prs_lz_hist_ram.sv @@
module prs_lz_hist_ram
	import prs_lz_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic [HIST_AW-1:0] waddr,
	input  logic [BYTE_W-1:0]  wdata,
	input  logic               re,
	input  logic [HIST_AW-1:0] raddr,
	output logic [BYTE_W-1:0]  rdata
);

	logic [BYTE_W-1:0] mem [HIST_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/prs_lz_ctrl.sv @@
module prs_lz_ctrl
	import prs_lz_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              command,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data,
	output step_t             step
);

	logic [CNT_W-1:0]  out_size_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [BYTE_W-1:0] ctrl_bits_q;
	logic [BL_W-1:0]   bits_left_q;
	phase_t            phase_q;
	logic [BYTE_W-1:0] low_byte_q;
	logic [DIST_W-1:0] dist_q;
	logic [COPY_W-1:0] copy_q;
	logic [SLEN_W-1:0] short_len_q;
	status_t           status_q;

	logic [CNT_W-1:0]  n_count;
	logic [BYTE_W-1:0] n_cb;
	logic [BL_W-1:0]   n_bl;
	phase_t            n_phase;
	logic [BYTE_W-1:0] n_low;
	logic [DIST_W-1:0] n_dist;
	logic [COPY_W-1:0] n_copy;
	logic [SLEN_W-1:0] n_sl;
	status_t           n_status;

	// parser walk results
	phase_t            p_ph;
	logic [BYTE_W-1:0] p_cb;
	logic [BL_W-1:0]   p_bl;
	logic [SLEN_W-1:0] p_sl;
	phase_t            p_act;
	logic              p_act_v;

	logic              cnt_ge;
	logic [CNT_W-1:0]  cnt_inc;
	logic [15:0]       word;
	logic [DIST_W-1:0] long_dist;
	logic [DIST_W-1:0] short_dist;
	logic [COPY_W-1:0] long_len;
	logic [COPY_W-1:0] ext_len;

	assign cnt_ge     = out_count_q >= out_size_q;
	assign cnt_inc    = out_count_q + CNT_W'(1);
	assign word       = {in_byte, low_byte_q};
	assign long_dist  = LONG_BASE - {1'b0, word[15:3]};
	assign short_dist = SHORT_BASE - {{(DIST_W-BYTE_W){1'b0}}, in_byte};
	assign long_len   = {{(COPY_W-3){1'b0}}, word[2:0]} + LONG_ADD;
	assign ext_len    = {1'b0, in_byte} + EXT_ADD;

	// control-bit walk for one fed byte: the byte serves as a control byte or as data
	always_comb begin
		phase_t            ph;
		logic [BYTE_W-1:0] cb;
		logic [BL_W-1:0]   bl;
		logic [SLEN_W-1:0] sl;
		logic              used;
		logic              done;
		logic              bit_v;
		phase_t            act;
		logic              act_v;
		ph    = phase_q;
		cb    = ctrl_bits_q;
		bl    = bits_left_q;
		sl    = short_len_q;
		used  = 1'b0;
		done  = 1'b0;
		bit_v = 1'b0;
		act   = PH_TOP;
		act_v = 1'b0;
		for (int i = 0; i < PARSE_STEPS; i++) begin
			if (!done) begin
				if (ph == PH_TOP || ph == PH_BIT || ph == PH_BIT2 || ph == PH_SHORT) begin
					// take one control bit, reloading from the byte when exhausted
					if (bl <= BL_W'(1)) begin
						if (used) begin
							done = 1'b1;
						end else begin
							used = 1'b1;
							cb   = in_byte;
							bl   = CTRL_BITS_N;
						end
					end else begin
						bl = bl - BL_W'(1);
					end
					if (!done) begin
						bit_v = cb[0];
						cb    = {1'b0, cb[BYTE_W-1:1]};
						unique case (ph)
							PH_TOP, PH_BIT: begin
								ph = bit_v ? PH_LIT : PH_BIT2;
							end
							PH_BIT2: begin
								if (bit_v) begin
									ph = PH_LO;
								end else begin
									sl = SLEN_W'(1);
									ph = PH_SHORT;
								end
							end
							default: begin
								if (sl == SLEN_W'(1)) begin
									sl = bit_v ? SLEN_W'(4) : SLEN_W'(2);
								end else begin
									sl = sl + SLEN_W'(bit_v);
									ph = PH_ONE;
								end
							end
						endcase
					end
				end else begin
					// data phase consumes the byte; only a stored literal keeps walking
					if (used) begin
						done = 1'b1;
					end else begin
						used  = 1'b1;
						act   = ph;
						act_v = 1'b1;
						if (ph == PH_LIT && !cnt_ge) begin
							ph = PH_BIT;
						end else begin
							done = 1'b1;
						end
					end
				end
			end
		end
		p_ph    = ph;
		p_cb    = cb;
		p_bl    = bl;
		p_sl    = sl;
		p_act   = act;
		p_act_v = act_v;
	end

	// next state and result for the accepted transaction
	always_comb begin
		status_t           status0;
		logic [DIST_W-1:0] cdist;
		logic [COPY_W-1:0] clen;
		status0  = (status_q == ST_RUN && phase_q == PH_TOP && copy_q == '0 && cnt_ge)
			? ST_END : status_q;
		cdist    = dist_q;
		clen     = '0;
		n_count  = out_count_q;
		n_cb     = ctrl_bits_q;
		n_bl     = bits_left_q;
		n_phase  = phase_q;
		n_low    = low_byte_q;
		n_dist   = dist_q;
		n_copy   = copy_q;
		n_sl     = short_len_q;
		n_status = status0;
		step.ov       = 1'b0;
		step.from_ram = 1'b0;
		step.lit      = in_byte;
		step.raddr    = out_count_q[HIST_AW-1:0] - dist_q[HIST_AW-1:0];
		step.waddr    = out_count_q[HIST_AW-1:0];
		if (command) begin
			// drain one copy byte
			if (status0 == ST_RUN && copy_q != '0) begin
				if (cnt_ge) begin
					n_status = ST_OVF;
				end else begin
					step.ov       = 1'b1;
					step.from_ram = 1'b1;
					n_count       = cnt_inc;
					n_copy        = copy_q - COPY_W'(1);
					if (copy_q == COPY_W'(1) && cnt_inc == out_size_q) begin
						n_status = ST_END;
					end
				end
			end
		end else if (status0 == ST_END || (status0 == ST_RUN && copy_q != '0)) begin
			n_status = ST_MISUSE;
		end else if (status0 == ST_RUN) begin
			n_phase = p_ph;
			n_cb    = p_cb;
			n_bl    = p_bl;
			n_sl    = p_sl;
			if (p_act_v) begin
				unique case (p_act)
					PH_LIT: begin
						if (cnt_ge) begin
							n_status = ST_OVF;
						end else begin
							step.ov = 1'b1;
							n_count = cnt_inc;
						end
					end
					PH_LO: begin
						n_low   = in_byte;
						n_phase = PH_HI;
					end
					PH_HI: begin
						if (word == '0) begin
							n_phase  = PH_TOP;
							n_status = ST_END;
						end else begin
							n_dist = long_dist;
							if (word[2:0] != '0) begin
								n_phase = PH_TOP;
								if ({{(CNT_W-DIST_W){1'b0}}, long_dist} > out_count_q) begin
									n_status = ST_SRC;
								end else begin
									n_copy = long_len;
								end
							end else begin
								n_sl    = '0;
								n_phase = PH_ONE;
							end
						end
					end
					PH_ONE: begin
						n_phase = PH_TOP;
						if (p_sl != '0) begin
							cdist = short_dist;
							clen  = {{(COPY_W-SLEN_W){1'b0}}, p_sl};
						end else begin
							clen  = ext_len;
						end
						n_dist = cdist;
						if ({{(CNT_W-DIST_W){1'b0}}, cdist} > out_count_q) begin
							n_status = ST_SRC;
						end else begin
							n_copy = clen;
						end
					end
					default: ;
				endcase
			end
		end
		if (n_status != ST_RUN) begin
			n_copy = '0;
		end
		step.pend   = n_copy != '0;
		step.status = n_status;
	end

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_size_q <= '0;
		end else if (cfg_wr_en) begin
			out_size_q <= cfg_wr_data;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_count_q <= '0;
			ctrl_bits_q <= '0;
			bits_left_q <= BL_W'(1);
			phase_q     <= PH_TOP;
			low_byte_q  <= '0;
			dist_q      <= '0;
			copy_q      <= '0;
			short_len_q <= '0;
			status_q    <= ST_RUN;
		end else if (accept) begin
			out_count_q <= n_count;
			ctrl_bits_q <= n_cb;
			bits_left_q <= n_bl;
			phase_q     <= n_phase;
			low_byte_q  <= n_low;
			dist_q      <= n_dist;
			copy_q      <= n_copy;
			short_len_q <= n_sl;
			status_q    <= n_status;
		end
	end

endmodule

@@ rtl/core/prs_lz_decompressor_top.sv @@
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: in_byte; tuser: command
// m_*       out  m_tvalid/m_tready  tdata: out_byte, copy_pending, status; tuser: out_valid
// cfg_*     in   cfg_wr_en          cfg_wr_data: out_size
//
// With m_tready high, one transaction per cycle each way; a result follows next cycle.
// A drain reads the history RAM once when accepted; the output stage writes its byte back
// while it holds it, with a bypass for a read of the entry the output stage is writing.
// Reset clears decoder state and output valid; history stays undefined until written.
// With a result waiting, m_tready low holds the output stage and drops s_tready that cycle.
module prs_lz_decompressor_top
	import prs_lz_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,     // [7:0] in_byte
	input  logic [0:0]        s_tuser,     // [0] command
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,     // [7:0] out_byte, [8] copy_pending, [11:9] status
	output logic [0:0]        m_tuser,     // [0] out_valid
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data
);

	logic               accept;
	step_t              step;
	logic [BYTE_W-1:0]  rdata;
	logic [BYTE_W-1:0]  out_byte_w;
	logic               fwd;

	logic               valid_s1;
	logic               ov_s1;
	logic               pend_s1;
	status_t            status_s1;
	logic               from_ram_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic [HIST_AW-1:0] waddr_s1;

	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	prs_lz_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (s_tuser[0]),
		.in_byte     (s_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (step)
	);

	prs_lz_hist_ram u_hist (
		.clk   (clk),
		.we    (valid_s1 && ov_s1),
		.waddr (waddr_s1),
		.wdata (out_byte_w),
		.re    (accept && step.from_ram),
		.raddr (step.raddr),
		.rdata (rdata)
	);

	// byte held by the output stage, from RAM or from the captured value
	assign out_byte_w = from_ram_s1 ? rdata : byte_s1;

	// bypass: new read hits the entry being written this cycle
	assign fwd = valid_s1 && ov_s1 && (waddr_s1 == step.raddr);

	// output stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (m_tready) begin
			valid_s1 <= 1'b0;
		end
	end

	// output stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ov_s1       <= step.ov;
			pend_s1     <= step.pend;
			status_s1   <= step.status;
			waddr_s1    <= step.waddr;
			from_ram_s1 <= step.from_ram && !fwd;
			byte_s1     <= step.from_ram ? out_byte_w : step.lit;
		end
	end

	assign m_tvalid = valid_s1;
	assign m_tdata  = {4'b0, status_s1, pend_s1, (ov_s1 ? out_byte_w : 8'h00)};
	assign m_tuser  = ov_s1;

endmodule

@@ tb/prs_lz_decode_checker.sv @@
`timescale 1ns / 100ps

module prs_lz_decode_checker
	import prs_lz_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [7:0]       s_tdata,     // [7:0] in_byte
	input  logic [0:0]       s_tuser,     // [0] command
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [15:0]      m_tdata,     // [7:0] out_byte, [8] copy_pending, [11:9] status
	input  logic [0:0]       m_tuser,     // [0] out_valid
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	output int               fail_count,
	output int               open_count,
	output int               byte_count,
	output status_t          last_status
);

	typedef struct packed {
		logic [7:0] obyte;
		logic       oval;
		logic       pend;
		status_t    st;
	} decoded_t;

	// decoder image
	logic [7:0]        hist_mem [HIST_DEPTH];
	logic [CNT_W-1:0]  produced_cnt;
	logic [CNT_W-1:0]  size_limit;
	logic [7:0]        ctl_shift;
	logic [BL_W-1:0]   ctl_left;
	phase_t            ph;
	logic [7:0]        word_lo;
	logic [DIST_W-1:0] match_dist;
	logic [COPY_W-1:0] copy_left;
	logic [SLEN_W-1:0] slen;
	status_t           st;

	decoded_t          decoded_q[$];

	// end of stream is only taken at a match boundary
	function automatic void close_if_done();
		if (st == ST_RUN && ph == PH_TOP && copy_left == '0 && produced_cnt >= size_limit) begin
			st = ST_END;
		end
	endfunction

	function automatic void start_copy(input logic [COPY_W-1:0] len);
		ph = PH_TOP;
		if (CNT_W'(match_dist) > produced_cnt) begin
			st = ST_SRC;
		end else begin
			copy_left = len;
		end
	endfunction

	// one input transaction in, one expected result out
	function automatic decoded_t decode_one(input logic is_drain, input logic [7:0] b);
		decoded_t          r;
		logic              took;
		logic              bitv;
		logic [15:0]       word;
		logic [HIST_AW-1:0] src;
		int                g;
		r.obyte = '0;
		r.oval = 1'b0;
		r.pend = 1'b0;
		r.st = ST_RUN;
		took = 1'b0;
		close_if_done();
		if (is_drain) begin
			if (st == ST_RUN && copy_left != '0) begin
				if (produced_cnt >= size_limit) begin
					st = ST_OVF;
				end else begin
					src = produced_cnt[HIST_AW-1:0] - match_dist[HIST_AW-1:0];
					r.obyte = hist_mem[src];
					hist_mem[produced_cnt[HIST_AW-1:0]] = r.obyte;
					r.oval = 1'b1;
					produced_cnt++;
					copy_left--;
					close_if_done();
				end
			end
		end else if (st == ST_END || (st == ST_RUN && copy_left != '0)) begin
			st = ST_MISUSE;
		end else begin
			// walk control bits until a second byte would be needed
			for (g = 0; g < 32; g++) begin
				if (st != ST_RUN || copy_left != '0) break;
				if (ph <= PH_SHORT) begin
					if (ctl_left <= BL_W'(1)) begin
						if (took) break;
						took = 1'b1;
						ctl_shift = b;
						ctl_left = CTRL_BITS_N;
					end else begin
						ctl_left--;
					end
					bitv = ctl_shift[0];
					ctl_shift = ctl_shift >> 1;
					case (ph)
						PH_TOP, PH_BIT: begin
							if (bitv) ph = PH_LIT;
							else ph = PH_BIT2;
						end
						PH_BIT2: begin
							if (bitv) begin
								ph = PH_LO;
							end else begin
								slen = SLEN_W'(1);
								ph = PH_SHORT;
							end
						end
						default: begin
							if (slen == SLEN_W'(1)) begin
								slen = bitv ? SLEN_W'(4) : SLEN_W'(2);
							end else begin
								slen = slen + SLEN_W'(bitv);
								ph = PH_ONE;
							end
						end
					endcase
				end else begin
					if (took) break;
					took = 1'b1;
					case (ph)
						PH_LIT: begin
							if (produced_cnt >= size_limit) begin
								st = ST_OVF;
							end else begin
								hist_mem[produced_cnt[HIST_AW-1:0]] = b;
								r.obyte = b;
								r.oval = 1'b1;
								produced_cnt++;
								ph = PH_BIT;
							end
						end
						PH_LO: begin
							word_lo = b;
							ph = PH_HI;
						end
						PH_HI: begin
							word = {b, word_lo};
							if (word == '0) begin
								ph = PH_TOP;
								st = ST_END;
							end else begin
								match_dist = LONG_BASE - DIST_W'(word[15:3]);
								if (word[2:0] != '0) begin
									start_copy(COPY_W'(word[2:0]) + LONG_ADD);
								end else begin
									slen = '0;
									ph = PH_ONE;
								end
							end
						end
						default: begin
							// short offset byte, or length byte of an extended long match
							if (slen != '0) begin
								match_dist = SHORT_BASE - DIST_W'(b);
								start_copy(COPY_W'(slen));
							end else begin
								start_copy(COPY_W'(b) + EXT_ADD);
							end
						end
					endcase
				end
			end
		end
		if (st != ST_RUN) copy_left = '0;
		r.pend = (copy_left != '0);
		r.st = st;
		return r;
	endfunction

	// track config, compare results, predict on accepted inputs
	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		decoded_t got;
		if (!arst_n) begin
			produced_cnt = '0;
			size_limit = '0;
			ctl_shift = '0;
			ctl_left = BL_W'(1);
			ph = PH_TOP;
			word_lo = '0;
			match_dist = '0;
			copy_left = '0;
			slen = '0;
			st = ST_RUN;
			decoded_q.delete();
			byte_count = 0;
			last_status = ST_RUN;
			open_count <= 0;
		end else begin
			if (cfg_wr_en) size_limit = cfg_wr_data;

			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%t ERROR: unexpected result: byte %h v %b p %b st %0d",
							$realtime, m_tdata[7:0], m_tuser[0], m_tdata[8], m_tdata[11:9]);
					end
				end else begin
					want = decoded_q.pop_front();
					if (m_tdata[7:0] !== want.obyte || m_tuser[0] !== want.oval ||
					    m_tdata[8] !== want.pend || m_tdata[11:9] !== want.st) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%t ERROR: exp %h v %b p %b st %s, got %h v %b p %b st %0d",
								$realtime, want.obyte, want.oval, want.pend, want.st.name(),
								m_tdata[7:0], m_tuser[0], m_tdata[8], m_tdata[11:9]);
						end
					end
				end
			end

			if (s_tvalid && s_tready) begin
				got = decode_one(s_tuser[0], s_tdata);
				if (got.oval) byte_count++;
				last_status = got.st;
				decoded_q.push_back(got);
			end

			open_count <= decoded_q.size();
		end
	end

endmodule

@@ tb/tb_prs_lz_decompressor_top.sv @@
`timescale 1ns / 100ps

module tb_prs_lz_decompressor_top;
	import prs_lz_pkg::*;

	localparam logic CMD_FEED  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;
	localparam int   STALL_LIMIT = 5000;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
	} stream_item_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;
	logic [0:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [15:0]      m_tdata;
	logic [0:0]       m_tuser;
	logic             cfg_wr_en = 1'b0;
	logic [CNT_W-1:0] cfg_wr_data = '0;

	int               fail_count;
	int               open_count;
	int               byte_count;
	status_t          last_status;

	int               stall_pct = 0;

	// compressed stream under construction
	stream_item_t     comp_stream[$];
	int               ctrl_slot;
	int               ctrl_used = 8;
	int               plan_bytes = 0;

	prs_lz_decompressor_top DUT (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.cfg_wr_en, .cfg_wr_data
	);

	prs_lz_decode_checker u_checker (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.cfg_wr_en, .cfg_wr_data,
		.fail_count, .open_count, .byte_count, .last_status
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

	// --- encoder: control bits LSB first, control byte placed where the decoder needs it

	function automatic void push_item(input logic cmd, input logic [7:0] data);
		stream_item_t it;
		it.cmd = cmd;
		it.data = data;
		comp_stream.push_back(it);
	endfunction

	function automatic void put_bit(input logic b);
		stream_item_t it;
		if (ctrl_used == 8) begin
			ctrl_slot = comp_stream.size();
			push_item(CMD_FEED, 8'h00);
			ctrl_used = 0;
		end
		it = comp_stream[ctrl_slot];
		it.data[ctrl_used] = b;
		comp_stream[ctrl_slot] = it;
		ctrl_used++;
	endfunction

	// occasional drain with nothing pending; the decoder must ignore it
	function automatic void put_byte(input logic [7:0] v);
		if ($urandom_range(19) == 0) push_item(CMD_DRAIN, 8'($urandom_range(255)));
		push_item(CMD_FEED, v);
	endfunction

	function automatic void put_drains(input int n);
		for (int i = 0; i < n; i++) push_item(CMD_DRAIN, 8'($urandom_range(255)));
	endfunction

	function automatic void add_literal(input logic [7:0] v);
		put_bit(1'b1);
		put_byte(v);
		plan_bytes++;
	endfunction

	// size 0 selects the extended form with length extra + 10
	function automatic void add_long(input int back_dist, input int size, input int extra);
		logic [15:0] word;
		int          len;
		word = {13'(8192 - back_dist), 3'(size)};
		put_bit(1'b0);
		put_bit(1'b1);
		put_byte(word[7:0]);
		put_byte(word[15:8]);
		if (size == 0) begin
			put_byte(8'(extra));
			len = extra + 10;
		end else begin
			len = size + 2;
		end
		put_drains(len);
		plan_bytes += len;
	endfunction

	function automatic void add_short(input int back_dist, input int len);
		put_bit(1'b0);
		put_bit(1'b0);
		put_bit(1'(((len - 2) >> 1) & 1));
		put_bit(1'((len - 2) & 1));
		put_byte(8'(256 - back_dist));
		put_drains(len);
		plan_bytes += len;
	endfunction

	// --- drivers

	task automatic write_size(input logic [CNT_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_slice(input int first, input int last, input int idle_pct, input int stall);
		int i;
		stall_pct = stall;
		for (i = first; i < last; i++) begin
			while ($urandom_range(99) < idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tuser <= comp_stream[i].cmd;
			s_tdata <= comp_stream[i].data;
			@(posedge clk);
			while (!s_tready) @(posedge clk);
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic settle();
		do @(posedge clk); while (open_count != 0);
	endtask

	// no-progress watchdog
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("prs_lz_decompressor_top verification failed");
		$finish;
	end

	initial begin : stimulus
		int dir_end;
		int rnd_first;
		int rnd_end;
		int q1;
		int q2;
		int q3;
		int kind;
		int cap;
		int back_dist;
		int total;
		int tail_kind;

		// directed: byte extremes, overlapping copies, every short length, both long forms
		add_literal(8'h00);
		add_literal(8'hFF);
		add_literal(8'hA5);
		add_literal(8'h5A);
		add_long(1, 7, 0);
		add_short(1, 2);
		add_short(4, 3);
		add_short(2, 4);
		add_short(plan_bytes, 5);
		add_long(plan_bytes, 1, 0);
		add_long(3, 0, 0);
		push_item(CMD_DRAIN, 8'hFF);
		add_literal(8'h3C);
		dir_end = comp_stream.size();

		// random well-formed tokens; one longest extended copy up front
		rnd_first = dir_end;
		add_long($urandom_range(plan_bytes, 1), 0, 255);
		while (comp_stream.size() < rnd_first + 410) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				add_literal(8'($urandom_range(255)));
			end else if (kind < 65) begin
				cap = (plan_bytes < 256) ? plan_bytes : 256;
				back_dist = ($urandom_range(3) == 0) ? cap : $urandom_range(cap, 1);
				add_short(back_dist, $urandom_range(5, 2));
			end else begin
				cap = (plan_bytes < 8192) ? plan_bytes : 8191;
				back_dist = ($urandom_range(3) == 0) ? cap : $urandom_range(cap, 1);
				if (kind < 90) add_long(back_dist, $urandom_range(7, 1), 0);
				else add_long(back_dist, 0, $urandom_range(30, 0));
			end
		end
		rnd_end = comp_stream.size();
		total = plan_bytes;
		q1 = rnd_first + (rnd_end - rnd_first) / 4;
		q2 = rnd_first + (rnd_end - rnd_first) / 2;
		q3 = rnd_first + 3 * (rnd_end - rnd_first) / 4;

		// terminal tail: optional end marker, then raw noise
		tail_kind = $urandom_range(2);
		if (tail_kind == 1) begin
			put_bit(1'b0);
			put_bit(1'b1);
			push_item(CMD_FEED, 8'h00);
			push_item(CMD_FEED, 8'h00);
		end
		repeat (24) push_item(1'($urandom_range(1)), 8'($urandom_range(255)));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_size(24'hFFFFFF);
		run_slice(0, dir_end, 0, 0);
		settle();
		write_size(CNT_W'(total));
		run_slice(rnd_first, q1, 69, 0);
		settle();
		write_size(CNT_W'($urandom_range(24'hFFFFFF, total)));
		run_slice(q1, q2, 0, 69);
		settle();
		write_size(24'hFFFFFF);
		run_slice(q2, q3, 11, 11);
		settle();
		run_slice(q3, rnd_end, 0, 0);
		settle();

		// sticky error and end handling
		if (tail_kind == 0) write_size('0);
		else if (tail_kind == 2) write_size(CNT_W'(total));
		run_slice(rnd_end, comp_stream.size(), 11, 11);
		settle();
		repeat (8) @(posedge clk);

		$display("Sent %0d stream transactions over five pacing phases and a noise tail",
			comp_stream.size());
		$display("Checked %0d decoded bytes; decoder finished in status %s",
			byte_count, last_status.name());
		if (fail_count == 0) begin
			$display("prs_lz_decompressor_top verification clean");
		end else begin
			$display("prs_lz_decompressor_top verification failed");
		end
		$finish;
	end

endmodule
